@@ rtl/sic_pkg.sv @@
// Shared types and constants for the Sampson inlier classifier.
// Used by every module of the block and by its checker; depends on nothing.

package sic_pkg;

  // Field widths of the correspondence stream.
  localparam int COORD_WIDTH = 16;
  localparam int INDEX_WIDTH = 16;
  localparam int COORD_FRAC  = COORD_WIDTH - 2;
  localparam int CNT_W       = INDEX_WIDTH + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << INDEX_WIDTH;

  // Matrix entries, threshold and its square.
  localparam int F_W         = 16;
  localparam int ROW_W       = 3 * F_W;
  localparam int THR_W       = 16;
  localparam int TT_W        = 2 * THR_W;
  localparam int THRESH_FRAC = 20;
  localparam int unsigned THR_RESET = 1573;
  localparam logic [TT_W-1:0] TT_RESET = TT_W'(THR_RESET * THR_RESET);

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ZERO,
    REG_ROW_ONE,
    REG_ROW_TWO,
    REG_THRESHOLD
  } cfg_reg_t;

  // Queue between the classifier pipeline and the result stage.
  localparam int QDEPTH = 16;
  localparam int QPTR_W = 4;
  localparam int QCNT_W = QPTR_W + 1;

  // Pipeline depth of the classifier.
  localparam int STAGES = 8;

  // One correspondence.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic [INDEX_WIDTH-1:0]        match_index;
    logic                          set_end;
  } match_t;

  // One classified correspondence.
  typedef struct packed {
    logic [INDEX_WIDTH-1:0] result_index;
    logic                   is_inlier;
    logic [CNT_W-1:0]       inlier_count;
    logic                   count_final;
  } result_t;

  // Side information carried down the pipeline.
  typedef struct packed {
    logic [INDEX_WIDTH-1:0] index;
    logic                   last;
  } meta_t;

  // Verdict handed from the classifier to the result stage.
  typedef struct packed {
    logic [INDEX_WIDTH-1:0] index;
    logic                   inlier;
    logic                   last;
  } class_t;

endpackage

@@ rtl/sic_front.sv @@
// Classifier pipeline: configuration registers and the eight-stage exact
// Sampson test. Depends on sic_pkg.

module sic_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [sic_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sic_pkg::ROW_W-1:0]      wr_data,
  input  logic                           take,
  input  sic_pkg::match_t                request,
  output logic                           out_valid,
  output sic_pkg::class_t                verdict
);
  import sic_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int P_W    = CW + F_W;
  localparam int L_W    = CW + 17;
  localparam int X_W    = CW + L_W;
  localparam int SQ_W   = 2 * L_W - 2;
  localparam int DEN_W  = SQ_W + 2;
  localparam int E_W    = 2 * CW + 17;
  localparam int MAG_W  = E_W - 1;
  localparam int LO_W   = MAG_W / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int NUM_W  = 2 * MAG_W;
  localparam int D_CH   = (DEN_W + 2) / 3;
  localparam int PAD_W  = 3 * D_CH;
  localparam int TP_W   = TT_W + D_CH;
  localparam int RHS_W  = TT_W + PAD_W;
  localparam int LHS_SH = 2 * THRESH_FRAC;
  localparam int RHS_SH = 2 * COORD_FRAC;
  localparam int CMP_W  = (NUM_W + LHS_SH > RHS_W + RHS_SH) ? NUM_W + LHS_SH
                                                           : RHS_W + RHS_SH;

  logic [ROW_W-1:0]        row [3];
  logic [TT_W-1:0]         tt;
  logic [TT_W-1:0]         thr_sq;
  logic signed [F_W-1:0]   f [9];
  logic [STAGES-1:0]       vld;
  meta_t                   meta [STAGES];

  // Stage registers.
  logic signed [P_W-1:0]   s1_x1f0, s1_y1f1, s1_x1f3, s1_y1f4, s1_x1f6, s1_y1f7;
  logic signed [P_W-1:0]   s1_x2f0, s1_y2f3, s1_x2f1, s1_y2f4;
  logic signed [CW-1:0]    s1_x2, s1_y2, s2_x2, s2_y2;
  logic signed [L_W-1:0]   s2_l0, s2_l1, s2_l2, s2_m0, s2_m1, s3_l2;
  logic signed [X_W-1:0]   s3_ex, s3_ey;
  logic [SQ_W-1:0]         s3_sq [4];
  logic signed [E_W-1:0]   s4_e;
  logic [DEN_W-1:0]        s4_den;
  logic [MAG_W-1:0]        s5_mag;
  logic [TP_W-1:0]         s5_tp [3];
  logic [2*HI_W-1:0]       s6_hh;
  logic [HI_W+LO_W-1:0]    s6_hl;
  logic [2*LO_W-1:0]       s6_ll;
  logic [RHS_W-1:0]        s6_rhs, s7_rhs;
  logic [NUM_W-1:0]        s7_num;
  logic                    s8_inl;

  // Full-width products between stages.
  logic signed [2*L_W-1:0] sq_full [4];
  logic signed [E_W-1:0]   e_neg;
  logic [PAD_W-1:0]        den_pad;
  logic [TP_W-1:0]         tp_full [3];
  logic [2*HI_W-1:0]       hh_full;
  logic [HI_W+LO_W-1:0]    hl_full;
  logic [2*LO_W-1:0]       ll_full;

  // Threshold is stored already squared.
  assign thr_sq = wr_data[THR_W-1:0] * wr_data[THR_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row[0] <= '0;
      row[1] <= '0;
      row[2] <= '0;
      tt     <= TT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_ROW_ZERO:  row[0] <= wr_data;
        REG_ROW_ONE:   row[1] <= wr_data;
        REG_ROW_TWO:   row[2] <= wr_data;
        REG_THRESHOLD: tt     <= thr_sq;
        default:       tt     <= tt;
      endcase
    end
  end

  // Unpack the nine matrix entries.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        f[3*r+c] = row[r][F_W*c +: F_W];
      end
    end
  end

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], take};
    end
  end

  // Side information follows its item.
  always_ff @(posedge clk) begin
    meta[0] <= '{index: request.match_index, last: request.set_end};
    for (int k = 1; k < STAGES; k++) begin
      meta[k] <= meta[k-1];
    end
  end

  // Combinational products feeding the stage registers.
  assign sq_full[0] = s2_l0 * s2_l0;
  assign sq_full[1] = s2_l1 * s2_l1;
  assign sq_full[2] = s2_m0 * s2_m0;
  assign sq_full[3] = s2_m1 * s2_m1;
  assign e_neg      = -s4_e;
  assign den_pad    = PAD_W'(s4_den);
  assign hh_full    = s5_mag[MAG_W-1 -: HI_W] * s5_mag[MAG_W-1 -: HI_W];
  assign hl_full    = s5_mag[MAG_W-1 -: HI_W] * s5_mag[LO_W-1:0];
  assign ll_full    = s5_mag[LO_W-1:0] * s5_mag[LO_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tp_full[k] = tt * den_pad[k*D_CH +: D_CH];
    end
  end

  // Arithmetic datapath, one multiply or one wide add per stage.
  always_ff @(posedge clk) begin
    // Stage 1: coordinate times matrix entry.
    s1_x1f0 <= request.first_x * f[0];
    s1_y1f1 <= request.first_y * f[1];
    s1_x1f3 <= request.first_x * f[3];
    s1_y1f4 <= request.first_y * f[4];
    s1_x1f6 <= request.first_x * f[6];
    s1_y1f7 <= request.first_y * f[7];
    s1_x2f0 <= request.second_x * f[0];
    s1_y2f3 <= request.second_y * f[3];
    s1_x2f1 <= request.second_x * f[1];
    s1_y2f4 <= request.second_y * f[4];
    s1_x2   <= request.second_x;
    s1_y2   <= request.second_y;
    // Stage 2: epipolar lines F*x1 and F^T*x2.
    s2_l0 <= L_W'(s1_x1f0) + L_W'(s1_y1f1) + (L_W'(f[2]) <<< COORD_FRAC);
    s2_l1 <= L_W'(s1_x1f3) + L_W'(s1_y1f4) + (L_W'(f[5]) <<< COORD_FRAC);
    s2_l2 <= L_W'(s1_x1f6) + L_W'(s1_y1f7) + (L_W'(f[8]) <<< COORD_FRAC);
    s2_m0 <= L_W'(s1_x2f0) + L_W'(s1_y2f3) + (L_W'(f[6]) <<< COORD_FRAC);
    s2_m1 <= L_W'(s1_x2f1) + L_W'(s1_y2f4) + (L_W'(f[7]) <<< COORD_FRAC);
    s2_x2 <= s1_x2;
    s2_y2 <= s1_y2;
    // Stage 3: residual terms and squared line terms.
    s3_ex <= s2_x2 * s2_l0;
    s3_ey <= s2_y2 * s2_l1;
    s3_l2 <= s2_l2;
    for (int k = 0; k < 4; k++) begin
      s3_sq[k] <= sq_full[k][SQ_W-1:0];
    end
    // Stage 4: residual and Sampson denominator.
    s4_e   <= E_W'(s3_ex) + E_W'(s3_ey) + (E_W'(s3_l2) <<< COORD_FRAC);
    s4_den <= DEN_W'(s3_sq[0]) + DEN_W'(s3_sq[1]) + DEN_W'(s3_sq[2])
              + DEN_W'(s3_sq[3]);
    // Stage 5: residual magnitude and threshold partial products.
    s5_mag <= s4_e[E_W-1] ? e_neg[MAG_W-1:0] : s4_e[MAG_W-1:0];
    for (int k = 0; k < 3; k++) begin
      s5_tp[k] <= tp_full[k];
    end
    // Stage 6: partial products of the squared residual and the summed threshold side.
    s6_hh  <= hh_full;
    s6_hl  <= hl_full;
    s6_ll  <= ll_full;
    s6_rhs <= RHS_W'(s5_tp[0]) + (RHS_W'(s5_tp[1]) << D_CH)
              + (RHS_W'(s5_tp[2]) << (2 * D_CH));
    // Stage 7: squared residual.
    s7_num <= (NUM_W'(s6_hh) << (2 * LO_W)) + (NUM_W'(s6_hl) << (LO_W + 1))
              + NUM_W'(s6_ll);
    s7_rhs <= s6_rhs;
    // Stage 8: exact comparison with both sides aligned.
    s8_inl <= (CMP_W'(s7_num) << LHS_SH) < (CMP_W'(s7_rhs) << RHS_SH);
  end

  assign out_valid = vld[STAGES-1];
  assign verdict   = '{index:  meta[STAGES-1].index,
                       inlier: s8_inl,
                       last:   meta[STAGES-1].last};

endmodule

@@ rtl/sic_queue.sv @@
// Queue of verdicts between the classifier pipeline and the result stage,
// with a registered read port. Depends on sic_pkg.

module sic_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  sic_pkg::class_t wdata,
  input  logic            rd,
  output logic            avail,
  output sic_pkg::class_t rdata
);
  import sic_pkg::*;

  class_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   mcnt;
  logic [QCNT_W-1:0]   mcnt_next;
  logic                dvalid;
  logic                fetch;

  // Refill the output register whenever it is free or being drained.
  assign fetch = (mcnt != '0) && (!dvalid || rd);
  assign avail = dvalid;

  always_comb begin
    mcnt_next = mcnt;
    if (wr && !fetch) begin
      mcnt_next = mcnt + QCNT_W'(1);
    end else if (!wr && fetch) begin
      mcnt_next = mcnt - QCNT_W'(1);
    end
  end

  // Storage array.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
    if (fetch) begin
      rdata <= mem[rptr];
    end
  end

  // Pointers, fill count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      mcnt   <= '0;
      dvalid <= 1'b0;
    end else begin
      mcnt <= mcnt_next;
      if (wr) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (fetch) begin
        rptr   <= rptr + QPTR_W'(1);
        dvalid <= 1'b1;
      end else if (rd) begin
        dvalid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/sic_back.sv @@
// Result stage: running inlier count per set and the result register.
// Depends on sic_pkg.

module sic_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             avail,
  input  sic_pkg::class_t  verdict,
  output logic             take,
  output logic             empty,
  input  logic             pop,
  output sic_pkg::result_t result
);
  import sic_pkg::*;

  logic [CNT_W-1:0] running;
  logic [CNT_W-1:0] count_next;
  logic             ovalid;

  // Take the next verdict when the result register is free or popped.
  assign take  = avail && (!ovalid || pop);
  assign empty = !ovalid;

  // Count including this item, saturating at the set size limit.
  always_comb begin
    count_next = running;
    if (verdict.inlier && (running != CNT_MAX)) begin
      count_next = running + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= '{result_index: verdict.index,
                  is_inlier:    verdict.inlier,
                  inlier_count: count_next,
                  count_final:  verdict.last};
    end
  end

  // Count restarts after the last item of a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (take) begin
        running <= verdict.last ? '0 : count_next;
        ovalid  <= 1'b1;
      end else if (pop) begin
        ovalid  <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/sampson_inlier_classifier_top.sv @@
// Top level of the Sampson inlier classifier: pipeline, queue, result stage
// and the credit counter that drives full. Depends on sic_pkg and submodules.

// Each correspondence goes through an eight-stage arithmetic pipeline that
// forms the epipolar residual and the Sampson denominator exactly and
// compares residual squared against threshold squared times denominator, so
// one transaction is accepted every cycle while full is low; its verdict then
// passes the queue storage, its read register and the result register. Up to
// sixteen transactions may sit in the pipeline and the verdict queue together;
// full rises when that budget is spent and falls as the result stage drains
// the queue. Writes to the matrix rows or the threshold must only happen while
// no transaction is in flight.

module sampson_inlier_classifier_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [sic_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sic_pkg::ROW_W-1:0]     wr_data,
  input  logic                          push,
  output logic                          full,
  input  sic_pkg::match_t               request,
  output logic                          empty,
  input  logic                          pop,
  output sic_pkg::result_t              result
);
  import sic_pkg::*;

  logic              take;
  logic              front_valid;
  class_t            front_verdict;
  logic              q_avail;
  class_t            q_verdict;
  logic              q_rd;
  logic [QCNT_W-1:0] occ;
  logic [QCNT_W-1:0] occ_next;

  assign take = push && !full;
  assign full = (occ == QCNT_W'(QDEPTH));

  // Credits: items in the pipeline plus items held in the queue.
  always_comb begin
    occ_next = occ;
    if (take && !q_rd) begin
      occ_next = occ + QCNT_W'(1);
    end else if (!take && q_rd) begin
      occ_next = occ - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  sic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .take      (take),
    .request   (request),
    .out_valid (front_valid),
    .verdict   (front_verdict)
  );

  sic_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (front_valid),
    .wdata (front_verdict),
    .rd    (q_rd),
    .avail (q_avail),
    .rdata (q_verdict)
  );

  sic_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (q_avail),
    .verdict (q_verdict),
    .take    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ rtl/sic_checker.sv @@
// Port-level checks for the Sampson inlier classifier, bound to its top
// level. Depends on sic_pkg and sampson_inlier_classifier_top.

module sic_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input sic_pkg::result_t result
);
  import sic_pkg::*;

  // Reset leaves no result waiting.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A result that is not taken stays unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // An inlier is always counted.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_inlier) |-> (result.inlier_count != '0))
    else $error("inlier reported with zero count");

  // Within a set the running count never drops.
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.count_final) |=>
      (empty || (result.inlier_count >= $past(result.inlier_count))))
    else $error("inlier count dropped within a set");

  // After the last item of a set the count starts again.
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && result.count_final) |=>
      (empty || (result.inlier_count <= CNT_W'(1))))
    else $error("inlier count did not restart after end of set");

endmodule

bind sampson_inlier_classifier_top sic_checker u_sic_checker (.*);

@@ tb/sampson_inlier_classifier_top_test.sv @@
// Self-checking testbench for the Sampson inlier classifier top level.
// Depends on sic_pkg and sampson_inlier_classifier_top; needs nothing else.
`timescale 1ns / 1ps

module sampson_inlier_classifier_top_test;
  import sic_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int LONG_SET_ITEMS = 40;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [ROW_W-1:0]     wr_data  = '0;
  logic                 push     = 1'b0;
  logic                 pop      = 1'b0;
  match_t               request  = '0;
  logic                 full;
  logic                 empty;
  result_t              result;

  // Shadow copy of the configuration and the running inlier tally.
  logic signed [F_W-1:0] f_entry [9] = '{default: '0};
  logic [THR_W-1:0]      thr_value   = THR_W'(THR_RESET);
  logic [CNT_W-1:0]      inlier_tally = '0;

  match_t  match_queue[$];
  result_t expected_results[$];

  logic [INDEX_WIDTH-1:0] next_index = '0;
  bit no_idle       = 1'b0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int send_gap      = 0;
  int take_gap      = 0;
  int pop_gap_draw  = 0;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int inliers_seen  = 0;
  int peak_count    = 0;
  int settings_run  = 0;
  int cycle_count   = 0;

  sampson_inlier_classifier_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .request  (request),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  // Clock and reset.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int draw_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Exact Sampson test: residual squared against threshold squared times
  // the denominator, both brought to the same binary point.
  function automatic result_t score_match(input match_t m);
    longint x1, y1, x2, y2, unit, l0, l1, l2, m0, m1, thr_s;
    logic signed [255:0] e, num, den, lhs, rhs;
    result_t r;
    logic hit;
    unit = longint'(1) << COORD_FRAC;
    x1 = m.first_x;
    y1 = m.first_y;
    x2 = m.second_x;
    y2 = m.second_y;
    l0 = x1 * f_entry[0] + y1 * f_entry[1] + f_entry[2] * unit;
    l1 = x1 * f_entry[3] + y1 * f_entry[4] + f_entry[5] * unit;
    l2 = x1 * f_entry[6] + y1 * f_entry[7] + f_entry[8] * unit;
    m0 = x2 * f_entry[0] + y2 * f_entry[3] + f_entry[6] * unit;
    m1 = x2 * f_entry[1] + y2 * f_entry[4] + f_entry[7] * unit;
    e = x2 * l0 + y2 * l1 + unit * l2;
    num = e * e;
    den = l0 * l0 + l1 * l1 + m0 * m0 + m1 * m1;
    thr_s = thr_value;
    lhs = num <<< (2 * THRESH_FRAC);
    rhs = (thr_s * thr_s * den) <<< (2 * COORD_FRAC);
    hit = lhs < rhs;
    if (hit && inlier_tally < CNT_MAX) inlier_tally = inlier_tally + 1'b1;
    r.result_index = m.match_index;
    r.is_inlier    = hit;
    r.inlier_count = inlier_tally;
    r.count_final  = m.set_end;
    if (m.set_end) inlier_tally = '0;
    return r;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // A correspondence placed near the epipolar line of its first point.
  function automatic match_t make_match(input logic [INDEX_WIDTH-1:0] idx, input logic last);
    match_t m;
    longint x1, y1, x2, y2, l0, l1, l2, unit, sol, a0, a1;
    longint noise;
    unit = longint'(1) << COORD_FRAC;
    x1 = longint'($urandom_range(0, 32767)) - 16384;
    y1 = longint'($urandom_range(0, 32767)) - 16384;
    x2 = longint'($urandom_range(0, 32767)) - 16384;
    y2 = longint'($urandom_range(0, 32767)) - 16384;
    l0 = x1 * f_entry[0] + y1 * f_entry[1] + f_entry[2] * unit;
    l1 = x1 * f_entry[3] + y1 * f_entry[4] + f_entry[5] * unit;
    l2 = x1 * f_entry[6] + y1 * f_entry[7] + f_entry[8] * unit;
    if ($urandom_range(0, 99) < 80) noise = longint'($urandom_range(0, 80)) - 40;
    else noise = longint'($urandom_range(0, 4000)) - 2000;
    a0 = (l0 < 0) ? -l0 : l0;
    a1 = (l1 < 0) ? -l1 : l1;
    if (a0 >= a1 && l0 != 0) begin
      sol = -(y2 * l1 + unit * l2) / l0;
      x2 = clamp_coord(sol + noise);
    end else if (l1 != 0) begin
      sol = -(x2 * l0 + unit * l2) / l1;
      y2 = clamp_coord(sol + noise);
    end
    m.first_x     = COORD_WIDTH'(x1);
    m.first_y     = COORD_WIDTH'(y1);
    m.second_x    = COORD_WIDTH'(x2);
    m.second_y    = COORD_WIDTH'(y2);
    m.match_index = idx;
    m.set_end     = last;
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 25) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // Compare one result transaction with the oldest prediction.
  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result for index %0d with none expected", got.result_index));
      return;
    end
    want = expected_results.pop_front();
    if (got.result_index !== want.result_index)
      report_mismatch($sformatf("result_index %0d, expected %0d",
                                got.result_index, want.result_index));
    if (got.is_inlier !== want.is_inlier)
      report_mismatch($sformatf("index %0d: is_inlier %0b, expected %0b",
                                want.result_index, got.is_inlier, want.is_inlier));
    if (got.inlier_count !== want.inlier_count)
      report_mismatch($sformatf("index %0d: inlier_count %0d, expected %0d",
                                want.result_index, got.inlier_count, want.inlier_count));
    if (got.count_final !== want.count_final)
      report_mismatch($sformatf("index %0d: count_final %0b, expected %0b",
                                want.result_index, got.count_final, want.count_final));
    results_seen++;
    if (want.is_inlier) inliers_seen++;
    if (int'(want.inlier_count) > peak_count) peak_count = int'(want.inlier_count);
  endtask

  // Driver: offers queued correspondences, predicting each one it hands over.
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      send_gap <= 0;
    end else begin
      if (push && !full) begin
        expected_results.insert(expected_results.size(), score_match(request));
        items_sent++;
      end
      if (push && full) begin
        // Keep offering the same transaction until it is taken.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push     <= 1'b0;
      end else if (match_queue.size() > 0) begin
        request  <= match_queue.pop_front();
        push     <= 1'b1;
        send_gap <= draw_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: takes results with random stalls and an occasional long hold.
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      take_gap  <= 0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) check_result(result);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        pop          <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        pop      <= 1'b0;
      end else if (pop && !empty) begin
        pop_gap_draw = draw_gap();
        if (pop_gap_draw == 0) begin
          pop <= 1'b1;
        end else begin
          pop      <= 1'b0;
          take_gap <= pop_gap_draw - 1;
        end
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (match_queue.size() != 0 || push || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [ROW_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    if (idx == REG_THRESHOLD) begin
      thr_value = data[THR_W-1:0];
    end else begin
      for (int j = 0; j < 3; j++) f_entry[3 * int'(idx) + j] = data[F_W*j +: F_W];
    end
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic write_matrix(input logic [8:0][F_W-1:0] fm);
    write_reg(REG_ROW_ZERO, {fm[2], fm[1], fm[0]});
    write_reg(REG_ROW_ONE,  {fm[5], fm[4], fm[3]});
    write_reg(REG_ROW_TWO,  {fm[8], fm[7], fm[6]});
  endtask

  task automatic queue_match(input logic [15:0] x1, input logic [15:0] y1,
                             input logic [15:0] x2, input logic [15:0] y2,
                             input logic [INDEX_WIDTH-1:0] idx, input logic last);
    match_t m;
    m.first_x     = x1;
    m.first_y     = y1;
    m.second_x    = x2;
    m.second_y    = y2;
    m.match_index = idx;
    m.set_end     = last;
    match_queue.insert(match_queue.size(), m);
  endtask

  // Sets of random length, mostly near-epipolar pairs, the rest raw noise.
  task automatic queue_random_sets(input int count);
    int left;
    int span;
    match_t m;
    left = count;
    while (left > 0) begin
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (span > left) span = left;
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(0, 15) == 0) next_index = INDEX_WIDTH'($urandom());
        if ($urandom_range(0, 99) < 75) begin
          m = make_match(next_index, i == span - 1);
        end else begin
          m.first_x     = COORD_WIDTH'($urandom());
          m.first_y     = COORD_WIDTH'($urandom());
          m.second_x    = COORD_WIDTH'($urandom());
          m.second_y    = COORD_WIDTH'($urandom());
          m.match_index = INDEX_WIDTH'($urandom());
          m.set_end     = 1'($urandom_range(0, 1));
        end
        match_queue.insert(match_queue.size(), m);
        next_index++;
      end
      left -= span;
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [8:0][F_W-1:0] fm;
    logic [THR_W-1:0] thr_pick;
    int r;
    @(negedge rst);

    // Reset configuration: the matrix is zero, so every denominator is zero.
    queue_match(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    queue_match(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 1'b0);
    queue_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b1);
    queue_match(16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 1'b1);
    wait_drained();
    settings_run++;

    // Only entry 2 set: the distance is |second_x|; largest threshold,
    // upper data bits set to show they are dropped.
    fm = '0;
    fm[2] = 16'h4000;
    write_matrix(fm);
    write_reg(REG_THRESHOLD, {32'hdead_beef, 16'hffff});
    queue_match(16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    queue_match(16'h7fff, 16'h8000, 16'h0001, 16'h7fff, 16'h0001, 1'b0);
    queue_match(16'h1234, 16'h4321, 16'd1023, 16'h0000, 16'h0002, 1'b0);
    queue_match(16'h1234, 16'h4321, 16'd1024, 16'h0000, 16'h0003, 1'b0);
    queue_match(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0004, 1'b1);
    queue_match(16'h0000, 16'h0000, 16'h7fff, 16'hffff, 16'hfffe, 1'b0);
    queue_match(16'h0000, 16'h0000, 16'hfc01, 16'h0000, 16'hffff, 1'b1);
    wait_drained();
    settings_run++;

    // Zero threshold: even a zero residual is not an inlier.
    write_reg(REG_THRESHOLD, {32'hffff_ffff, 16'h0000});
    queue_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0010, 1'b0);
    queue_match(16'h7fff, 16'h7fff, 16'h0000, 16'h7fff, 16'h0011, 1'b1);
    wait_drained();
    settings_run++;

    // Extreme matrices against extreme coordinates.
    for (int k = 0; k < 9; k++) fm[k] = 16'h8000;
    write_matrix(fm);
    write_reg(REG_THRESHOLD, 48'hffff);
    queue_match(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0020, 1'b0);
    queue_match(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0021, 1'b1);
    wait_drained();
    for (int k = 0; k < 9; k++) fm[k] = 16'h7fff;
    write_matrix(fm);
    queue_match(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0030, 1'b0);
    queue_match(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0031, 1'b1);
    wait_drained();
    settings_run += 2;

    // Random matrices and thresholds, one phase per setting.
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 9; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) fm[k] = 16'h8000;
        else if (r == 1) fm[k] = 16'h7fff;
        else fm[k] = F_W'($urandom());
      end
      write_matrix(fm);
      case (p)
        0: thr_pick = THR_W'(THR_RESET);
        1: thr_pick = '0;
        2: thr_pick = '1;
        default: thr_pick = THR_W'($urandom_range(200, 20000));
      endcase
      write_reg(REG_THRESHOLD, {32'($urandom()), thr_pick});
      no_idle = (p == 4);
      // Stall the result side long enough for the block to fill up.
      if (p == 3) holds_asked++;
      queue_random_sets(90);
      wait_drained();
      settings_run++;
    end

    // One long set of guaranteed inliers keeps the running count climbing.
    no_idle = 1'b1;
    fm = '0;
    fm[2] = 16'h4000;
    write_matrix(fm);
    write_reg(REG_THRESHOLD, 48'(THR_RESET));
    for (int i = 0; i < LONG_SET_ITEMS; i++) begin
      queue_match(16'($urandom()), 16'($urandom()), 16'h0000, 16'($urandom()), next_index,
                  i == LONG_SET_ITEMS - 1);
      next_index++;
    end
    queue_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, next_index, 1'b1);
    wait_drained();
    settings_run++;

    $display("Checked %0d correspondences over %0d register settings: %0d inliers,",
             results_seen, settings_run, inliers_seen);
    $display("peak running count %0d, %0d transactions offered by the driver.",
             peak_count, items_sent);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
